@@ sv/lpt_pkg.sv @@
`timescale 1ns / 1ps

package lpt_pkg;

  // Timer channels and the width of a channel number
  localparam int NUM_CH = 3;
  localparam int CH_W   = 2;

  // Port numbers
  localparam logic [9:0] PORT_CH0      = 10'h040;
  localparam logic [9:0] PORT_CH2      = 10'h042;
  localparam logic [9:0] PORT_CTRL     = 10'h043;
  localparam logic [9:0] PORT_GATE     = 10'h061;
  localparam logic [9:0] PORT_SYS      = 10'h062;
  localparam logic [9:0] PORT_CMOS_IDX = 10'h070;
  localparam logic [9:0] PORT_CMOS_DAT = 10'h071;

  // Counter access modes (control byte bits 5:4)
  localparam logic [1:0] MODE_LATCH = 2'd0;
  localparam logic [1:0] MODE_LO    = 2'd1;
  localparam logic [1:0] MODE_HI    = 2'd2;
  localparam logic [1:0] MODE_LOHI  = 2'd3;

  // Access direction
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [7:0] BYTE_UNCLAIMED = 8'hFF;
  localparam logic [1:0] GATE_BOTH      = 2'b11;
  localparam logic [CH_W-1:0] SPK_CH    = 2'd2;

  // Reset values of the timer channels
  localparam logic [15:0] RELOAD_INIT [NUM_CH] = '{16'hFFFF, 16'h0012, 16'h0001};
  localparam logic [7:0]  CTRL_INIT   [NUM_CH] = '{8'h36, 8'h74, 8'hB6};

  // CMOS contents after reset; bytes 0x2E/0x2F hold the sum of 0x10..0x2C
  localparam int CMOS_TBL_BYTES = 64;
  localparam logic [7:0] CMOS_INIT [CMOS_TBL_BYTES] = '{
    8'h27, 8'h34, 8'h31, 8'h47, 8'h16, 8'h15, 8'h00, 8'h01,
    8'h04, 8'h94, 8'h26, 8'h02, 8'h50, 8'h80, 8'h00, 8'h00,
    8'h40, 8'hb1, 8'h00, 8'h9c, 8'h01, 8'h80, 8'h02, 8'h00,
    8'h3b, 8'h00, 8'h00, 8'had, 8'h02, 8'h10, 8'h00, 8'h00,
    8'h08, 8'h00, 8'h00, 8'h26, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3f, 8'h03, 8'h38,
    8'h00, 8'h1c, 8'h19, 8'h81, 8'h00, 8'h0e, 8'h00, 8'h80,
    8'h1b, 8'h7b, 8'h21, 8'h00, 8'h00, 8'h00, 8'h05, 8'h5f
  };

  // One port access
  typedef struct packed {
    logic        action;
    logic [9:0]  port_address;
    logic [7:0]  write_data;
    logic [15:0] live_count;
  } req_t;

  // Timer response to one access
  typedef struct packed {
    logic            claimed;
    logic [7:0]      read_data;
    logic            changed;
    logic [CH_W-1:0] channel;
    logic [15:0]     value;
  } pit_res_t;

  // Reset contents of one CMOS byte; entries beyond the table are zero
  function automatic logic [7:0] cmos_init(input logic [6:0] idx);
    logic [7:0] res;
    res = 8'h00;
    if (idx < 7'(CMOS_TBL_BYTES)) begin
      res = CMOS_INIT[idx[5:0]];
    end
    return res;
  endfunction

endpackage

@@ sv/lpt_ram.sv @@
`timescale 1ns / 1ps

module lpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lpt_cmos.sv @@
`timescale 1ns / 1ps

module lpt_cmos #(
  parameter int CMOS_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic          accept,
  input  lpt_pkg::req_t req,
  output logic [6:0]    cmos_idx,
  output logic [7:0]    rd_data
);

  localparam int SLOT_W = $clog2(CMOS_BYTES);
  localparam logic [7:0] LIMIT = 8'(CMOS_BYTES);

  logic [6:0]        idx_r;
  logic [6:0]        idx_nxt;
  logic [CMOS_BYTES-1:0] valid_r;
  logic              wr;
  logic [SLOT_W-1:0] wslot;
  logic [SLOT_W-1:0] rslot;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;
  logic              vld_r;
  logic [7:0]        init_r;
  logic [7:0]        ram_q;

  // Index modulo the store size; the index stays below twice the size
  function automatic logic [SLOT_W-1:0] slot_of(input logic [6:0] idx);
    logic [7:0] wide;
    wide = {1'b0, idx};
    if (wide >= LIMIT) begin
      wide = wide - LIMIT;
    end
    return wide[SLOT_W-1:0];
  endfunction

  // Index register and store write for the access being retired
  always_comb begin
    idx_nxt = idx_r;
    if (fire && req.action == lpt_pkg::ACT_WRITE &&
        req.port_address == lpt_pkg::PORT_CMOS_IDX) begin
      idx_nxt = req.write_data[6:0];
    end
    wr    = fire && req.action == lpt_pkg::ACT_WRITE &&
            req.port_address == lpt_pkg::PORT_CMOS_DAT;
    wslot = slot_of(idx_r);
    rslot = slot_of(idx_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (wr) begin
        valid_r[wslot] <= 1'b1;
      end
    end
  end

  // The read is issued as a request is taken, with the index it will see
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r      <= wr && (wslot == rslot);
      fwd_data_r <= req.write_data;
      vld_r      <= valid_r[rslot];
      init_r     <= lpt_pkg::cmos_init(7'(rslot));
    end
  end

  lpt_ram #(
    .WIDTH(8),
    .DEPTH(CMOS_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (wr),
    .waddr(wslot),
    .wdata(req.write_data),
    .re   (accept),
    .raddr(rslot),
    .rdata(ram_q)
  );

  // A byte never written reads as its reset contents
  assign rd_data  = fwd_r ? fwd_data_r : (vld_r ? ram_q : init_r);
  assign cmos_idx = idx_r;

endmodule

@@ sv/lpt_pit.sv @@
`timescale 1ns / 1ps

module lpt_pit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  lpt_pkg::req_t      req,
  output lpt_pkg::pit_res_t  res,
  output logic [15:0]        reload2
);

  logic [15:0] reload_r  [lpt_pkg::NUM_CH];
  logic [15:0] reload_nxt[lpt_pkg::NUM_CH];
  logic [15:0] latch_r   [lpt_pkg::NUM_CH];
  logic [15:0] latch_nxt [lpt_pkg::NUM_CH];
  logic [15:0] old_r     [lpt_pkg::NUM_CH];
  logic [15:0] old_nxt   [lpt_pkg::NUM_CH];
  logic [7:0]  ctrl_r    [lpt_pkg::NUM_CH];
  logic [7:0]  ctrl_nxt  [lpt_pkg::NUM_CH];
  logic [lpt_pkg::NUM_CH-1:0] latched_r;
  logic [lpt_pkg::NUM_CH-1:0] latched_nxt;
  logic [lpt_pkg::NUM_CH-1:0] toggle_r;
  logic [lpt_pkg::NUM_CH-1:0] toggle_nxt;

  logic                     is_ch;
  logic                     is_ctrl;
  logic                     is_wr;
  logic [lpt_pkg::CH_W-1:0] c;
  logic [lpt_pkg::CH_W-1:0] cc;
  logic [1:0]               cm;
  logic [15:0]              cur_reload;
  logic [15:0]              cur_latch;
  logic [15:0]              cur_old;
  logic [7:0]               cur_ctrl;
  logic                     cur_latched;
  logic                     cur_tog;
  logic [1:0]               mode;
  logic [15:0]              t;
  logic [15:0]              r;
  logic [15:0]              old_v;
  logic                     hi;
  logic                     tog_n;
  logic                     clr_latch;

  // Select the addressed channel and work out the access
  always_comb begin
    is_ch   = req.port_address >= lpt_pkg::PORT_CH0 &&
              req.port_address <= lpt_pkg::PORT_CH2;
    is_ctrl = req.port_address == lpt_pkg::PORT_CTRL;
    is_wr   = req.action == lpt_pkg::ACT_WRITE;
    c       = req.port_address[1:0];
    cc      = req.write_data[7:6];
    cm      = req.write_data[5:4];

    cur_reload  = reload_r[0];
    cur_latch   = latch_r[0];
    cur_old     = old_r[0];
    cur_ctrl    = ctrl_r[0];
    cur_latched = latched_r[0];
    cur_tog     = toggle_r[0];
    for (int i = 1; i < lpt_pkg::NUM_CH; i++) begin
      if (c == lpt_pkg::CH_W'(i)) begin
        cur_reload  = reload_r[i];
        cur_latch   = latch_r[i];
        cur_old     = old_r[i];
        cur_ctrl    = ctrl_r[i];
        cur_latched = latched_r[i];
        cur_tog     = toggle_r[i];
      end
    end

    mode  = cur_ctrl[5:4];
    t     = cur_latched ? cur_latch : req.live_count;
    tog_n = (mode == lpt_pkg::MODE_LOHI) ? !cur_tog : cur_tog;
    hi    = (mode == lpt_pkg::MODE_LOHI) ? cur_tog : 1'b1;

    // Counter read
    res           = '0;
    res.claimed   = is_ch || (is_ctrl && is_wr);
    res.read_data = 8'h00;
    clr_latch     = 1'b0;
    case (mode)
      lpt_pkg::MODE_LATCH: begin
        res.read_data = 8'h00;
      end
      lpt_pkg::MODE_LO: begin
        res.read_data = t[7:0];
        clr_latch     = 1'b1;
      end
      default: begin
        res.read_data = hi ? t[15:8] : t[7:0];
        clr_latch     = hi;
      end
    endcase

    // Counter write
    old_v = (mode != lpt_pkg::MODE_LOHI || !cur_tog) ? cur_reload : cur_old;
    r     = cur_reload;
    case (mode)
      lpt_pkg::MODE_LATCH: r = cur_reload;
      lpt_pkg::MODE_LO:    r = {cur_reload[15:8], req.write_data};
      default: begin
        r = hi ? {req.write_data, cur_reload[7:0]} : {cur_reload[15:8], req.write_data};
      end
    endcase
    if (is_ch && is_wr && (mode != lpt_pkg::MODE_LOHI || !tog_n) && r != old_v) begin
      res.changed = 1'b1;
      res.channel = c;
      res.value   = r;
    end

    // Next state per channel
    for (int i = 0; i < lpt_pkg::NUM_CH; i++) begin
      reload_nxt[i]  = reload_r[i];
      latch_nxt[i]   = latch_r[i];
      old_nxt[i]     = old_r[i];
      ctrl_nxt[i]    = ctrl_r[i];
      latched_nxt[i] = latched_r[i];
      toggle_nxt[i]  = toggle_r[i];
      if (fire && is_ch && c == lpt_pkg::CH_W'(i)) begin
        toggle_nxt[i] = tog_n;
        if (is_wr) begin
          reload_nxt[i] = r;
          old_nxt[i]    = old_v;
        end else if (clr_latch) begin
          latched_nxt[i] = 1'b0;
        end
      end
      if (fire && is_ctrl && is_wr && cc == lpt_pkg::CH_W'(i)) begin
        if (cm == lpt_pkg::MODE_LATCH) begin
          latched_nxt[i] = 1'b1;
          latch_nxt[i]   = req.live_count;
        end else begin
          if (cm == lpt_pkg::MODE_LOHI) begin
            toggle_nxt[i] = 1'b0;
          end
          ctrl_nxt[i] = req.write_data;
        end
      end
    end
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpt_pkg::NUM_CH; i++) begin
        reload_r[i] <= lpt_pkg::RELOAD_INIT[i];
        latch_r[i]  <= '0;
        old_r[i]    <= '0;
        ctrl_r[i]   <= lpt_pkg::CTRL_INIT[i];
      end
      latched_r <= '0;
      toggle_r  <= '0;
    end else begin
      for (int i = 0; i < lpt_pkg::NUM_CH; i++) begin
        reload_r[i] <= reload_nxt[i];
        latch_r[i]  <= latch_nxt[i];
        old_r[i]    <= old_nxt[i];
        ctrl_r[i]   <= ctrl_nxt[i];
      end
      latched_r <= latched_nxt;
      toggle_r  <= toggle_nxt;
    end
  end

  assign reload2 = reload_r[lpt_pkg::SPK_CH];

endmodule

@@ sv/legacy_pc_timer_cmos_ports.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Contents
// request   in         in_tvalid/in_tready/in_tdata   one byte-wide port access
// result    out        out_tvalid/out_tready/out_tdata one response per access
//
// Each request is held in the input register and is retired into the output
// register once that register is free; one request per cycle is sustained
// while the result is not stalled. out_tvalid is set by the output register,
// after the request has passed through the input register; the registered CMOS
// read issued as the request is taken is ready while the request waits there.
// Reset is synchronous and active low; the CMOS store reads its reset
// contents through per-byte valid flags, so no clearing pass is needed.
// A stalled result holds the input register, which in turn drops in_tready.
module legacy_pc_timer_cmos_ports #(
  parameter int CMOS_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] action, [10:1] port_address, [18:11] write_data, [34:19] live_count
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] claimed, [9] reload_changed, [11:10] reload_channel,
  // [27:12] reload_value, [28] speaker_request, [44:29] speaker_divisor
  output logic [47:0] out_tdata
);

  logic              in_valid_r;
  lpt_pkg::req_t     req_r;
  logic              fire;
  logic              accept;
  lpt_pkg::pit_res_t pit_res;
  logic [15:0]       reload2;
  logic [6:0]        cmos_idx;
  logic [7:0]        cmos_rd;
  logic [7:0]        gate_r;
  logic [7:0]        gate_nxt;

  logic        out_valid_r;
  logic [7:0]  rd_nxt,  rd_r;
  logic        clm_nxt, clm_r;
  logic        chg_nxt, chg_r;
  logic [1:0]  ch_nxt,  ch_r;
  logic [15:0] val_nxt, val_r;
  logic        spk_nxt, spk_r;
  logic [15:0] div_nxt, div_r;

  // Handshake: the input register moves on when the output register is free
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.action       <= in_tdata[0];
      req_r.port_address <= in_tdata[10:1];
      req_r.write_data   <= in_tdata[18:11];
      req_r.live_count   <= in_tdata[34:19];
    end
  end

  lpt_pit u_pit (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .req    (req_r),
    .res    (pit_res),
    .reload2(reload2)
  );

  lpt_cmos #(
    .CMOS_BYTES(CMOS_BYTES)
  ) u_cmos (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .accept  (accept),
    .req     (req_r),
    .cmos_idx(cmos_idx),
    .rd_data (cmos_rd)
  );

  // Port decode and result assembly
  always_comb begin
    rd_nxt   = (req_r.action == lpt_pkg::ACT_WRITE) ? 8'h00 : lpt_pkg::BYTE_UNCLAIMED;
    clm_nxt  = 1'b0;
    chg_nxt  = 1'b0;
    ch_nxt   = '0;
    val_nxt  = '0;
    spk_nxt  = 1'b0;
    div_nxt  = '0;
    gate_nxt = gate_r;
    case (req_r.port_address) inside
      [lpt_pkg::PORT_CH0:lpt_pkg::PORT_CTRL]: begin
        clm_nxt = pit_res.claimed;
        if (pit_res.claimed && req_r.action == lpt_pkg::ACT_READ) begin
          rd_nxt = pit_res.read_data;
        end
        chg_nxt = pit_res.changed;
        ch_nxt  = pit_res.channel;
        val_nxt = pit_res.value;
        if (pit_res.changed && pit_res.channel == lpt_pkg::SPK_CH &&
            gate_r[1:0] == lpt_pkg::GATE_BOTH) begin
          spk_nxt = 1'b1;
          div_nxt = pit_res.value;
        end
      end
      lpt_pkg::PORT_GATE: begin
        clm_nxt = 1'b1;
        if (req_r.action == lpt_pkg::ACT_READ) begin
          rd_nxt = gate_r;
        end else begin
          if (fire) begin
            gate_nxt = req_r.write_data;
          end
          if (req_r.write_data[1:0] == lpt_pkg::GATE_BOTH && reload2 != 16'h0001) begin
            spk_nxt = 1'b1;
            div_nxt = reload2;
          end
        end
      end
      lpt_pkg::PORT_SYS: begin
        clm_nxt = (req_r.action == lpt_pkg::ACT_READ);
      end
      lpt_pkg::PORT_CMOS_IDX: begin
        clm_nxt = 1'b1;
        if (req_r.action == lpt_pkg::ACT_READ) begin
          rd_nxt = {1'b0, cmos_idx};
        end
      end
      lpt_pkg::PORT_CMOS_DAT: begin
        clm_nxt = 1'b1;
        if (req_r.action == lpt_pkg::ACT_READ) begin
          rd_nxt = cmos_rd;
        end
      end
      default: begin
        clm_nxt = 1'b0;
      end
    endcase
  end

  // Speaker gate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r <= 8'h20;
    end else begin
      gate_r <= gate_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r  <= rd_nxt;
      clm_r <= clm_nxt;
      chg_r <= chg_nxt;
      ch_r  <= ch_nxt;
      val_r <= val_nxt;
      spk_r <= spk_nxt;
      div_r <= div_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, div_r, spk_r, val_r, ch_r, chg_r, clm_r, rd_r};

endmodule
